/* design/dfla_pkg.sv */
// Shared types and codes for the deferred free-list allocator.
// No dependencies; used by dfla_ctrl, dfla_dp and the top level.
package dfla_pkg;

	localparam int DEF_POOL_DEPTH = 256;
	localparam int POOL_SIZE_RESET = 256;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_MAF   = 2'd3
	} mode_t;

	localparam logic [1:0] STS_DONE      = 2'd0;
	localparam logic [1:0] STS_EXHAUSTED = 2'd1;
	localparam logic [1:0] STS_IGNORED   = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // latch request, issue link-table read
		logic exec;     // apply operation, load result word
		logic link;     // second write of an append
		logic sweep;    // one step of the make-all-free walk
		logic cfg_wr;   // new pool size, restart walk
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_done;
		logic need_link;
		logic mode_maf;
	} sts_t;

endpackage

/* design/deferred_free_list_allocator.sv */
// Top level of the deferred free-list allocator.
// Depends on dfla_pkg, dfla_ctrl and dfla_dp.
//
// Usage notes
// - Request channel (in_valid/in_stall): one word carries mode and
//   entry_index. Modes: allocate, deferred free, flush, make all free.
// - Result channel (out_valid/out_stall): exactly one word per request,
//   in request order: granted, granted_index, status, pool_empty.
// - Config channel (cfg_valid/cfg_ready, pool_size): write only when idle.
//   A write saturates pool_size to POOL_DEPTH and rebuilds all chains.
// - Timing: the link table has one write port and a registered read, so a
//   request has an accept step and an execute step. A free appended behind a
//   non-empty deferred chain needs a second table write. Make all free
//   returns its word from the execute step, then walks the table, one entry
//   per cycle, before the next request is taken.
// - Reset and every pool_size write run the same walk, with in_stall high
//   until it ends.
// - When out_stall is held, a finished request waits in its execute cycle
//   with no state changed until the output register frees up; the result
//   register then hands over the word with no bubble on the output side.
module deferred_free_list_allocator import dfla_pkg::*; #(
	parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] entry_index,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       granted,
	output logic [7:0] granted_index,
	output logic [1:0] status,
	output logic       pool_empty,
	// config write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] pool_size
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: idle / execute / append link / table walk
	dfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// link table, chain pointers and result register
	dfla_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.entry_index   (entry_index),
		.pool_size     (pool_size),
		.granted       (granted),
		.granted_index (granted_index),
		.status        (status),
		.pool_empty    (pool_empty)
	);

`ifndef SYNTH
	// a config write always starts a table walk, so requests are held off
	a_cfg_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("request accepted right after config write");

	// at most one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted back to back");

	// a grant only comes with a clean status
	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> status == STS_DONE)
		else $error("grant with error status");
`endif

endmodule

/* design/dfla_ctrl.sv */
// Controller state machine for the deferred free-list allocator.
// Depends on dfla_pkg (cmd_t, sts_t).
module dfla_ctrl import dfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_LINK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	// a config word takes the idle slot, so requests hold off that cycle
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_INIT);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.cfg_wr = cfg_valid && cfg_ready;
		cmd.accept = (state_q == S_IDLE) && in_valid && !cmd.cfg_wr;
		cmd.exec   = (state_q == S_EXEC) && slot_free;
		cmd.link   = (state_q == S_LINK);
		cmd.sweep  = (state_q == S_INIT) && !sts.sweep_done && !cmd.cfg_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cmd.cfg_wr) begin
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						if (sts.sweep_done)
							state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (in_valid)
							state_q <= S_EXEC;
					end
					S_EXEC: begin
						if (slot_free) begin
							if (sts.mode_maf)
								state_q <= S_INIT;
							else if (sts.need_link)
								state_q <= S_LINK;
							else
								state_q <= S_IDLE;
						end
					end
					S_LINK: begin
						state_q <= S_IDLE;
					end
					default: begin
						state_q <= S_INIT;
					end
				endcase
			end
		end
	end

endmodule

/* design/dfla_dp.sv */
// Datapath: link table memory, chain heads/tail, sweep counter, result word.
// Depends on dfla_pkg (cmd_t, sts_t, mode and status codes).
module dfla_dp import dfla_pkg::*; #(
	parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [1:0] mode,
	input  logic [7:0] entry_index,
	input  logic [8:0] pool_size,
	output logic       granted,
	output logic [7:0] granted_index,
	output logic [1:0] status,
	output logic       pool_empty
);

	// link values reach cap+1, cap <= POOL_DEPTH
	localparam int LW = $clog2(POOL_DEPTH + 2);
	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam logic [LW-1:0] RESET_CAP =
		(POOL_SIZE_RESET > POOL_DEPTH) ? LW'(POOL_DEPTH) : LW'(POOL_SIZE_RESET);

	logic [LW-1:0] link_mem [POOL_DEPTH];

	logic [LW-1:0] cap_q, act_q, dhead_q, dtail_q, cnt_q;
	logic [LW-1:0] rd_q;
	mode_t         req_mode_q;
	logic [7:0]    req_idx_q;
	logic          granted_q, empty_q;
	logic [7:0]    gidx_q;
	logic [1:0]    status_q;

	logic [LW-1:0] new_cap, used_mark, idx_lw;
	logic          alloc_ok, free_ok, flush_ok, append;
	logic [LW-1:0] act_n, dhead_n, dtail_n;
	logic          granted_n;
	logic [7:0]    gidx_n;
	logic [1:0]    status_n;
	logic          wr_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [LW-1:0] wr_data;

	assign new_cap   = (32'(pool_size) > POOL_DEPTH) ? LW'(POOL_DEPTH) : LW'(pool_size);
	assign used_mark = LW'(cap_q + 1'b1);
	assign idx_lw    = LW'(req_idx_q);

	assign alloc_ok = act_q < cap_q;
	assign free_ok  = (32'(req_idx_q) < 32'(cap_q)) && (rd_q == used_mark);
	assign flush_ok = (dhead_q != cap_q) && (dtail_q < cap_q);
	assign append   = free_ok && !((dhead_q == cap_q) || (dtail_q >= cap_q));

	always_comb begin
		act_n     = act_q;
		dhead_n   = dhead_q;
		dtail_n   = dtail_q;
		granted_n = 1'b0;
		gidx_n    = '0;
		status_n  = STS_DONE;
		case (req_mode_q)
			MODE_ALLOC: begin
				if (alloc_ok) begin
					act_n     = rd_q;
					granted_n = 1'b1;
					gidx_n    = 8'(act_q);
				end else begin
					status_n = STS_EXHAUSTED;
				end
			end
			MODE_FREE: begin
				if (!free_ok) begin
					status_n = STS_IGNORED;
				end else if (!append) begin
					dhead_n = idx_lw;
					dtail_n = idx_lw;
				end
			end
			MODE_FLUSH: begin
				if (flush_ok) begin
					act_n   = dhead_q;
					dhead_n = cap_q;
					dtail_n = cap_q;
				end
			end
			default: begin
				act_n   = '0;
				dhead_n = cap_q;
				dtail_n = cap_q;
			end
		endcase
	end

	// single write port: sweep, execute or append link
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IW-1:0];
		wr_data = LW'(cnt_q + 1'b1);
		if (cmd.sweep) begin
			wr_en = 1'b1;
		end else if (cmd.link) begin
			wr_en   = 1'b1;
			wr_addr = dtail_q[IW-1:0];
			wr_data = idx_lw;
		end else if (cmd.exec) begin
			case (req_mode_q)
				MODE_ALLOC: begin
					wr_en   = alloc_ok;
					wr_addr = act_q[IW-1:0];
					wr_data = used_mark;
				end
				MODE_FREE: begin
					wr_en   = free_ok;
					wr_addr = IW'(req_idx_q);
					wr_data = cap_q;
				end
				MODE_FLUSH: begin
					wr_en   = flush_ok;
					wr_addr = dtail_q[IW-1:0];
					wr_data = act_q;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	assign rd_addr = (mode_t'(mode) == MODE_FREE) ? IW'(entry_index) : act_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en)
			link_mem[wr_addr] <= wr_data;
		if (cmd.accept)
			rd_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_mode_q <= mode_t'(mode);
			req_idx_q  <= entry_index;
		end
		if (cmd.exec) begin
			granted_q <= granted_n;
			gidx_q    <= gidx_n;
			status_q  <= status_n;
			empty_q   <= (act_n == cap_q) && (dhead_n == cap_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= RESET_CAP;
			act_q   <= '0;
			dhead_q <= RESET_CAP;
			dtail_q <= RESET_CAP;
			cnt_q   <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q   <= new_cap;
			act_q   <= '0;
			dhead_q <= new_cap;
			dtail_q <= new_cap;
			cnt_q   <= '0;
		end else begin
			if (cmd.sweep)
				cnt_q <= LW'(cnt_q + 1'b1);
			if (cmd.exec) begin
				act_q   <= act_n;
				dhead_q <= dhead_n;
				dtail_q <= dtail_n;
				if (req_mode_q == MODE_MAF)
					cnt_q <= '0;
			end
			if (cmd.link)
				dtail_q <= idx_lw;
		end
	end

	assign sts.sweep_done = (cnt_q == cap_q);
	assign sts.need_link  = (req_mode_q == MODE_FREE) && append;
	assign sts.mode_maf   = (req_mode_q == MODE_MAF);

	assign granted       = granted_q;
	assign granted_index = gidx_q;
	assign status        = status_q;
	assign pool_empty    = empty_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for deferred_free_list_allocator: directed and random request streams,
// each result word checked against an in-bench allocator predictor.
// Depends on dfla_pkg and the deferred_free_list_allocator RTL.
module tb_top;
	import dfla_pkg::*;

	localparam int DEPTH          = DEF_POOL_DEPTH;
	localparam int WATCHDOG_LIMIT = 2000;  // > one full-table walk plus both idle draws
	localparam int DRAIN_CYCLES   = 300;   // a make-all-free walk may still run at the end
	localparam int MAX_PRINTS     = 30;

	// one expected result word
	typedef struct {
		logic       granted;
		logic [7:0] granted_index;
		logic [1:0] status;
		logic       pool_empty;
	} grant_word_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [1:0] mode        = MODE_ALLOC;
	logic [7:0] entry_index = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic       granted;
	logic [7:0] granted_index;
	logic [1:0] status;
	logic       pool_empty;
	logic       cfg_valid   = 1'b0;
	logic       cfg_ready;
	logic [8:0] pool_size   = 9'(POOL_SIZE_RESET);

	deferred_free_list_allocator #(.POOL_DEPTH(DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.entry_index  (entry_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.granted_index(granted_index),
		.status       (status),
		.pool_empty   (pool_empty),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.pool_size    (pool_size)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Allocator predictor: link table, chain heads, current pool size.
	// Link entries hold next index, end mark (cap) or used mark (cap + 1).
	// ------------------------------------------------------------------
	logic [8:0]  next_link [DEPTH];
	logic [8:0]  act_head;
	logic [8:0]  def_head;
	logic [8:0]  def_tail;
	logic [8:0]  cur_pool;
	grant_word_t due_replies [$];

	int idle_max;           // 0 turns off both sides' idling
	int out_hold;           // output stall cycles still to go
	int quiet;              // cycles with no handshake on any channel
	int mismatches;
	int words_checked;
	int n_req [4];
	int n_granted, n_exhausted, n_ignored, n_cfg;

	// pool_size saturates to the table depth
	function automatic logic [8:0] pool_cap();
		return (cur_pool > 9'(DEPTH)) ? 9'(DEPTH) : cur_pool;
	endfunction

	// make-all-free: chain 0..cap-1 in order, deferred chain empty
	function automatic void rebuild_chains();
		logic [8:0] cap;
		cap = pool_cap();
		act_head = 9'd0;    // also right for cap 0: head 0 equals the end mark
		def_head = cap;
		def_tail = cap;
		for (int i = 0; i < cap; i++)
			next_link[i] = (i + 1 < cap) ? 9'(i + 1) : cap;
	endfunction

	// apply one accepted request, return the word it must produce
	function automatic grant_word_t predict_reply(input mode_t m, input logic [7:0] idx);
		logic [8:0]  cap;
		logic [8:0]  used_mark;
		logic [8:0]  e;
		grant_word_t r;
		cap = pool_cap();
		used_mark = cap + 9'd1;
		r.granted = 1'b0;
		r.granted_index = 8'd0;
		r.status = STS_DONE;
		case (m)
			MODE_ALLOC: begin
				if (act_head >= cap) begin
					r.status = STS_EXHAUSTED;
				end else begin
					e = act_head;
					act_head = next_link[e];
					next_link[e] = used_mark;
					r.granted = 1'b1;
					r.granted_index = e[7:0];
				end
			end
			MODE_FREE: begin
				// out of range or not handed out: dropped, flagged
				if ({1'b0, idx} >= cap || next_link[idx] != used_mark) begin
					r.status = STS_IGNORED;
				end else begin
					next_link[idx] = cap;
					if (def_head == cap || def_tail >= cap)
						def_head = {1'b0, idx};
					else
						next_link[def_tail] = {1'b0, idx};
					def_tail = {1'b0, idx};
				end
			end
			MODE_FLUSH: begin
				// empty deferred chain: no change
				if (def_head != cap && def_tail < cap) begin
					next_link[def_tail] = act_head;
					act_head = def_head;
					def_head = cap;
					def_tail = cap;
				end
			end
			default: begin
				rebuild_chains();
			end
		endcase
		r.pool_empty = (act_head == cap && def_head == cap);
		n_req[m]++;
		if (r.granted)
			n_granted++;
		if (r.status == STS_EXHAUSTED)
			n_exhausted++;
		if (r.status == STS_IGNORED)
			n_ignored++;
		return r;
	endfunction

	// a random entry currently handed out, or -1 when none is
	function automatic int pick_used_entry();
		int         cand [$];
		logic [8:0] cap;
		cap = pool_cap();
		for (int i = 0; i < cap; i++)
			if (next_link[i] == cap + 9'd1)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers. Every task starts and ends in the step of a rising
	// edge, so in_valid for a back-to-back word is never dropped and raised
	// in one step.
	// ------------------------------------------------------------------
	task automatic send_request(input mode_t m, input logic [7:0] idx);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		do @(posedge clk); while (in_stall);
		due_replies.push_back(predict_reply(m, idx));
	endtask

	task automatic release_request();
		in_valid <= 1'b0;
	endtask

	// register write only once every word of the phase has come back
	task automatic write_pool_size(input logic [8:0] v);
		release_request();
		while (due_replies.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		pool_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_pool = v;
		rebuild_chains();
		n_cfg++;
	endtask

	// ------------------------------------------------------------------
	// Result side: random output stall, one compare per accepted word.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_word();
		grant_word_t want;
		words_checked++;
		if (due_replies.size() == 0) begin
			report_mismatch("result word with no request outstanding");
		end else begin
			want = due_replies.pop_front();
			if (granted !== want.granted)
				report_mismatch($sformatf("granted %b, want %b", granted, want.granted));
			if (granted_index !== want.granted_index)
				report_mismatch($sformatf("granted_index %0d, want %0d",
					granted_index, want.granted_index));
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", status, want.status));
			if (pool_empty !== want.pool_empty)
				report_mismatch($sformatf("pool_empty %b, want %b",
					pool_empty, want.pool_empty));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_word();
			out_hold = $urandom_range(0, idle_max);
		end else if (out_hold != 0) begin
			out_hold--;
		end
		out_stall <= (out_hold != 0);
	end

	// Ends the run when no channel moves a word for too long.
	initial begin : watchdog
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Edge cases at reset size, a two-entry pool, an empty pool and an
	// oversized pool.
	task automatic test_directed();
		idle_max = 11;
		send_request(MODE_FREE, 8'd0);      // never handed out
		send_request(MODE_FLUSH, 8'd0);     // empty deferred chain
		send_request(MODE_ALLOC, 8'hff);    // gets 0, index ignored
		send_request(MODE_ALLOC, 8'd0);     // gets 1
		send_request(MODE_FREE, 8'hff);     // in range, not in use
		send_request(MODE_FREE, 8'd1);      // starts the deferred chain
		send_request(MODE_FREE, 8'd0);      // appended behind 1
		send_request(MODE_FREE, 8'd0);      // second free of the same entry
		send_request(MODE_ALLOC, 8'd0);     // deferred ones not yet usable: 2
		send_request(MODE_FLUSH, 8'd0);     // 1, 0 go in front
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_MAF, 8'd0);
		write_pool_size(9'd2);
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_ALLOC, 8'd0);     // exhausted, pool empty
		send_request(MODE_FREE, 8'd2);      // out of range
		send_request(MODE_FREE, 8'd1);      // only deferred entry
		send_request(MODE_FLUSH, 8'd0);
		send_request(MODE_ALLOC, 8'd0);
		write_pool_size(9'd0);
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_FREE, 8'd0);
		send_request(MODE_FLUSH, 8'd0);
		send_request(MODE_MAF, 8'd0);
		write_pool_size(9'h1ff);            // saturates to the table depth
		send_request(MODE_ALLOC, 8'd0);
	endtask

	// Hand out the whole table (index 255 and exhaustion), give back about
	// half in random order while the active chain is empty, then flush.
	task automatic test_fill_and_drain();
		int pick;
		write_pool_size(9'(DEPTH));
		idle_max = 11;
		repeat (DEPTH + 1)
			send_request(MODE_ALLOC, 8'($urandom));
		repeat (DEPTH / 2) begin
			pick = pick_used_entry();
			if (pick >= 0 && $urandom_range(0, 9) != 0)
				send_request(MODE_FREE, 8'(pick));
			else
				send_request(MODE_FREE, 8'($urandom));
		end
		send_request(MODE_ALLOC, 8'd0);     // still exhausted
		send_request(MODE_FLUSH, 8'd0);
		repeat (20)
			send_request(MODE_ALLOC, 8'($urandom));
		send_request(MODE_MAF, 8'd0);
	endtask

	// Mostly well-formed traffic: frees target entries in use, a few
	// random frees as noise.
	task automatic test_random_mix(input logic [8:0] psize, input int n_items,
			input int alloc_pct, input int idle);
		int r;
		int pick;
		write_pool_size(psize);
		idle_max = idle;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			pick = pick_used_entry();
			if (r < alloc_pct)
				send_request(MODE_ALLOC, 8'($urandom));
			else if (r < alloc_pct + 32 && pick >= 0)
				send_request(MODE_FREE, 8'(pick));
			else if (r < alloc_pct + 44)
				send_request(MODE_FLUSH, 8'($urandom));
			else if (r < alloc_pct + 47)
				send_request(MODE_MAF, 8'($urandom));
			else
				send_request(MODE_FREE, 8'($urandom));
		end
	endtask

	initial begin
		idle_max = 0;
		out_hold = 0;
		mismatches = 0;
		words_checked = 0;
		n_granted = 0;
		n_exhausted = 0;
		n_ignored = 0;
		n_cfg = 0;
		foreach (n_req[i])
			n_req[i] = 0;
		// predictor reset state
		foreach (next_link[i])
			next_link[i] = 9'd0;
		cur_pool = 9'(POOL_SIZE_RESET);
		rebuild_chains();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_drain();
		test_random_mix(9'd8, 150, 45, 11);
		test_random_mix(9'd1, 40, 50, 11);
		test_random_mix(9'(DEPTH), 120, 55, 0);   // back-to-back, no stall
		test_random_mix(9'd0, 20, 45, 11);
		repeat (4)
			test_random_mix(9'($urandom_range(2, 40)), 40, 45, 11);
		test_random_mix(9'h1ff, 60, 50, 11);

		// drain: every word back, then let a last walk finish
		release_request();
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests: alloc %0d, free %0d, flush %0d, make-all-free %0d; %0d pool writes",
			n_req[MODE_ALLOC] + n_req[MODE_FREE] + n_req[MODE_FLUSH] + n_req[MODE_MAF],
			n_req[MODE_ALLOC], n_req[MODE_FREE], n_req[MODE_FLUSH], n_req[MODE_MAF], n_cfg);
		$display("%0d grants, %0d exhausted, %0d ignored frees; %0d words checked, %0d mismatches",
			n_granted, n_exhausted, n_ignored, words_checked, mismatches);
		if (mismatches == 0 && due_replies.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
